// ===== hdl/selection_sort_max_to_end_unit_defines.svh =====
// Assertion macros for the selection sort unit.
// Both macros expect clk and arst_n in the scope where they are used.
`ifndef SELECTION_SORT_MAX_TO_END_UNIT_DEFINES_SVH
`define SELECTION_SORT_MAX_TO_END_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSME_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SSME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSME_ASSERT(lbl, prop, msg)
`define SSME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/ssme_pkg.sv =====
package ssme_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int WORD_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_SWAP_A  = 6'b000100,
		ST_SWAP_B  = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_LD = 6'b100000
	} state_t;

	typedef struct packed {
		logic              vld;
		logic              first;
		logic [ADDR_W-1:0] idx;
	} scan_ctl_t;

endpackage

// ===== hdl/selection_sort_max_to_end_unit.sv =====
// Selection sort unit for sets of signed 32-bit words.
// The item channel (item_valid, item_stall, value, last) takes one word per
// transfer; last closes the set. Up to 64 words are kept, and further words
// of the same set are dropped and reported through overflow on every result.
// While collecting, a word is taken every cycle. After the closing transfer
// the item channel stalls until sorting and readout are complete.
// Sorting a set of n words runs passes over a shrinking prefix of the store;
// each pass moves the prefix maximum to the prefix end. Every compare
// needs one read of the store feeding the shared compare unit.
// The result channel (result_valid, result_stall, sorted_value, end_of_set,
// overflow) then gives the words in ascending order, each one read from
// the store and then loaded for output; end_of_set marks the final word.
// A stall on the result channel holds the current result and pauses readout.
// The last result may wait in the output register while the next set is
// collected. Reset clears the set count, the overflow flag and the output
// valid; the store itself is not cleared.
`include "selection_sort_max_to_end_unit_defines.svh"

module selection_sort_max_to_end_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic signed [ssme_pkg::WORD_W-1:0]   value,
	input  logic                                 last,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [ssme_pkg::WORD_W-1:0]   sorted_value,
	output logic                                 end_of_set,
	output logic                                 overflow
);

	ssme_pkg::state_t state_q, state_d;

	logic [ssme_pkg::CNT_W-1:0] count_q;
	logic                       ovf_q;
	logic [ssme_pkg::CNT_W-1:0] set_len_q;
	logic                       set_ovf_q;
	logic [ssme_pkg::CNT_W-1:0] span_q;
	logic [ssme_pkg::CNT_W-1:0] rd_idx_q;
	logic                       res_valid_q;

	logic                       rd_vld_s1;
	logic                       rd_first_s1;
	logic [ssme_pkg::ADDR_W-1:0] rd_idx_s1;

	logic signed [ssme_pkg::WORD_W-1:0] store_q [ssme_pkg::MAX_ITEMS];
	logic signed [ssme_pkg::WORD_W-1:0] rd_data_q;
	logic signed [ssme_pkg::WORD_W-1:0] tail_q;
	logic signed [ssme_pkg::WORD_W-1:0] sorted_value_q;
	logic                               end_q;
	logic                               ovf_out_q;

	logic                                item_acc;
	logic                                store_full;
	logic [ssme_pkg::CNT_W-1:0]          new_len;
	logic [ssme_pkg::CNT_W-1:0]          span_m1;
	logic                                scan_issue;
	logic                                scan_last;
	logic                                out_free;
	logic                                emit_load;
	logic                                emit_last;
	logic                                wr_en;
	logic [ssme_pkg::ADDR_W-1:0]         wr_addr;
	logic signed [ssme_pkg::WORD_W-1:0]  wr_data;
	logic [ssme_pkg::ADDR_W-1:0]         rd_addr;
	ssme_pkg::scan_ctl_t                 scan_ctl;
	logic signed [ssme_pkg::WORD_W-1:0]  best_val;
	logic [ssme_pkg::ADDR_W-1:0]         best_pos;

	assign item_stall = (state_q != ssme_pkg::ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign store_full = (count_q == ssme_pkg::CNT_W'(ssme_pkg::MAX_ITEMS));
	assign new_len    = store_full ? count_q : count_q + 1'b1;
	assign span_m1    = span_q - 1'b1;
	assign scan_issue = (state_q == ssme_pkg::ST_SCAN) && (rd_idx_q != span_q);
	assign scan_last  = rd_vld_s1 && (ssme_pkg::CNT_W'(rd_idx_s1) == span_m1);
	assign out_free   = !res_valid_q || !result_stall;
	assign emit_load  = (state_q == ssme_pkg::ST_EMIT_LD) && out_free;
	assign emit_last  = (rd_idx_q == set_len_q - 1'b1);
	assign rd_addr    = rd_idx_q[ssme_pkg::ADDR_W-1:0];

	assign scan_ctl.vld   = rd_vld_s1;
	assign scan_ctl.first = rd_first_s1;
	assign scan_ctl.idx   = rd_idx_s1;

	ssme_max_scan u_scan (
		.clk      (clk),
		.ctl      (scan_ctl),
		.data     (rd_data_q),
		.best_val (best_val),
		.best_pos (best_pos)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[ssme_pkg::ADDR_W-1:0];
		wr_data = value;
		unique case (state_q)
			ssme_pkg::ST_IDLE: begin
				wr_en = item_acc && !store_full;
			end
			ssme_pkg::ST_SWAP_A: begin
				wr_en   = 1'b1;
				wr_addr = best_pos;
				wr_data = tail_q;
			end
			ssme_pkg::ST_SWAP_B: begin
				wr_en   = 1'b1;
				wr_addr = span_m1[ssme_pkg::ADDR_W-1:0];
				wr_data = best_val;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_data_q <= store_q[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssme_pkg::ST_IDLE: begin
				if (item_acc && last) begin
					state_d = (new_len > ssme_pkg::CNT_W'(1)) ? ssme_pkg::ST_SCAN
					                                          : ssme_pkg::ST_EMIT_RD;
				end
			end
			ssme_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = ssme_pkg::ST_SWAP_A;
				end
			end
			ssme_pkg::ST_SWAP_A: begin
				state_d = ssme_pkg::ST_SWAP_B;
			end
			ssme_pkg::ST_SWAP_B: begin
				state_d = (span_m1 == ssme_pkg::CNT_W'(1)) ? ssme_pkg::ST_EMIT_RD
				                                           : ssme_pkg::ST_SCAN;
			end
			ssme_pkg::ST_EMIT_RD: begin
				state_d = ssme_pkg::ST_EMIT_LD;
			end
			ssme_pkg::ST_EMIT_LD: begin
				if (out_free) begin
					state_d = emit_last ? ssme_pkg::ST_IDLE : ssme_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ssme_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssme_pkg::ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			set_len_q   <= '0;
			set_ovf_q   <= 1'b0;
			span_q      <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (item_acc) begin
				if (last) begin
					count_q   <= '0;
					ovf_q     <= 1'b0;
					set_len_q <= new_len;
					set_ovf_q <= ovf_q || store_full;
					span_q    <= new_len;
					rd_idx_q  <= '0;
				end else if (store_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (scan_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (state_q == ssme_pkg::ST_SWAP_B) begin
				span_q   <= span_m1;
				rd_idx_q <= '0;
			end
			if (emit_load) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (emit_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_first_s1 <= (rd_idx_q == '0);
		rd_idx_s1   <= rd_idx_q[ssme_pkg::ADDR_W-1:0];
		if (scan_last) begin
			tail_q <= rd_data_q;
		end
		if (emit_load) begin
			sorted_value_q <= rd_data_q;
			end_q          <= emit_last;
			ovf_out_q      <= set_ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign sorted_value = sorted_value_q;
	assign end_of_set   = end_q;
	assign overflow     = ovf_out_q;

	`SSME_ASSERT(a_count_bound, count_q <= ssme_pkg::CNT_W'(ssme_pkg::MAX_ITEMS), "count beyond capacity")
	`SSME_ASSERT(a_scan_span, (state_q != ssme_pkg::ST_SCAN) || ((span_q > ssme_pkg::CNT_W'(1)) && (span_q <= set_len_q)), "scan span out of range")
	`SSME_ASSERT_NEXT(a_span_step, state_q == ssme_pkg::ST_SWAP_B, span_q == $past(span_q) - 1'b1, "span did not shrink after swap")
	`SSME_ASSERT_NEXT(a_end_idle, emit_load && emit_last, (state_q == ssme_pkg::ST_IDLE) && result_valid && end_of_set, "set end not followed by idle")

endmodule

// ===== hdl/ssme_max_scan.sv =====
// Running maximum over a stream of words; ties keep the earlier position.
module ssme_max_scan (
	input  logic                                 clk,
	input  ssme_pkg::scan_ctl_t                  ctl,
	input  logic signed [ssme_pkg::WORD_W-1:0]   data,
	output logic signed [ssme_pkg::WORD_W-1:0]   best_val,
	output logic        [ssme_pkg::ADDR_W-1:0]   best_pos
);

	logic signed [ssme_pkg::WORD_W-1:0] best_val_q;
	logic        [ssme_pkg::ADDR_W-1:0] best_pos_q;

	always_ff @(posedge clk) begin
		if (ctl.vld && (ctl.first || (data > best_val_q))) begin
			best_val_q <= data;
			best_pos_q <= ctl.idx;
		end
	end

	assign best_val = best_val_q;
	assign best_pos = best_pos_q;

endmodule
